// ----- rtl/cda_pkg.sv -----
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, constants and calendar helpers for the Gregorian date unit.
// ----------------------------------------------------------------------------
package cda_pkg;

    // Field widths
    localparam int unsigned DAY_W  = 5;
    localparam int unsigned MON_W  = 4;
    localparam int unsigned YEAR_W = 14;
    localparam int unsigned OFS_W  = 16;
    localparam int unsigned CNT_W  = 22;
    localparam int unsigned DIY_W  = 9;   // day within year, up to 459 with month field 15

    localparam int unsigned DEF_MAX_YEAR = 9999;

    // Serial day of 1 January, year 1 (year 0 counts 366 days)
    localparam int unsigned LO_SERIAL = 367;

    // Saturation value of the day difference
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Last year index of the 400-year leap cycle
    localparam logic [8:0] CYCLE_LAST = 9'd399;

    // Operation codes
    typedef enum logic [2:0] {
        FN_ADD  = 3'd0,
        FN_SUB  = 3'd1,
        FN_DIFF = 3'd2,
        FN_DOY  = 3'd3,
        FN_CMP  = 3'd4
    } t_func;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_EVAL,
        S_DIFF_B,
        S_ABS1,
        S_ABS2,
        S_OFS,
        S_CHK,
        S_FIND,
        S_REM,
        S_MON,
        S_DONE
    } t_state;

    // Leap test from the year modulo 400
    function automatic logic leap_of(input logic [8:0] m400);
        logic century;
        century = (m400 == 9'd100) || (m400 == 9'd200) || (m400 == 9'd300);
        return (m400[1:0] == 2'd0) && !century;
    endfunction

    // Month length; months outside 1..12 count 31 days
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in all months below m, common year
    function automatic logic [DIY_W-1:0] cum_days(input logic [MON_W-1:0] m);
        logic [DIY_W-1:0] c;
        case (m)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            4'd13:   c = 9'd365;
            4'd14:   c = 9'd396;
            4'd15:   c = 9'd427;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    // Day field plus all months below the month field
    function automatic logic [DIY_W-1:0] day_in_year(input logic [DAY_W-1:0] d,
                                                     input logic [MON_W-1:0] m,
                                                     input logic leap);
        logic feb;
        feb = leap && (m > 4'd2);
        return DIY_W'(d) + cum_days(m) + DIY_W'(feb);
    endfunction

endpackage

// ----- rtl/cda_alu.sv -----
// ----------------------------------------------------------------------------
// cda_alu
// Shared add/subtract unit of the date sequencer, with carry out.
// ----------------------------------------------------------------------------
module cda_alu #(
    parameter int unsigned W = 23
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W-1:0] o_sum,
    output logic         o_cout
);

    logic [W-1:0] b_op;

    // two's complement subtract; carry out high means a >= b on subtract
    assign b_op = i_sub ? ~i_b : i_b;
    assign {o_cout, o_sum} = {1'b0, i_a} + {1'b0, b_op} + (W+1)'(i_sub);

endmodule

// ----- rtl/calendar_date_arithmetic.sv -----
// ----------------------------------------------------------------------------
// calendar_date_arithmetic
// Gregorian date unit: add/subtract days, day difference, day of year and
// compare, built as a year walker and month walker around one shared adder.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | to unit   | i_in_valid / o_in_ready   | func, two dates, offset
//  out     | from unit | o_out_valid / i_out_ready | result date, count, flags
//
//  One item at a time. The year walker steps through every year from year 0 up to
//  the target year (the later year for a difference), then evaluates. Difference
//  adds the second serial and one or two subtracts; add/subtract adds the offset,
//  a range check, a second walk up to the result year, the day within that year
//  and a walk over the months; the result then waits in the output state.
//  Synchronous active-low reset idles the sequencer; a result holds until taken.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic #(
    parameter int unsigned MAX_YEAR = cda_pkg::DEF_MAX_YEAR
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_func,
    input  logic [cda_pkg::DAY_W-1:0]    i_first_day,
    input  logic [cda_pkg::MON_W-1:0]    i_first_month,
    input  logic [cda_pkg::YEAR_W-1:0]   i_first_year,
    input  logic [cda_pkg::DAY_W-1:0]    i_second_day,
    input  logic [cda_pkg::MON_W-1:0]    i_second_month,
    input  logic [cda_pkg::YEAR_W-1:0]   i_second_year,
    input  logic [cda_pkg::OFS_W-1:0]    i_offset_days,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [cda_pkg::DAY_W-1:0]    o_result_day,
    output logic [cda_pkg::MON_W-1:0]    o_result_month,
    output logic [cda_pkg::YEAR_W-1:0]   o_result_year,
    output logic [cda_pkg::CNT_W-1:0]    o_day_count,
    output logic                         o_first_greater,
    output logic                         o_dates_equal,
    output logic                         o_first_valid,
    output logic                         o_range_error
);

    import cda_pkg::*;

    // Year counter covers the walk to any input year and up to MAX_YEAR
    localparam int unsigned Y_TOP  = (MAX_YEAR + 1 > 16384) ? MAX_YEAR + 1 : 16384;
    localparam int unsigned Y_W    = $clog2(Y_TOP);
    localparam int unsigned DBY_TOP = 365 * Y_TOP + (Y_TOP + 3) / 4
                                      - (Y_TOP + 99) / 100 + (Y_TOP + 399) / 400;
    localparam int unsigned SER_W  = $clog2(DBY_TOP + 428 + 65536);
    // Serial day of 31 December of MAX_YEAR
    localparam int unsigned HI_SERIAL = 365 * (MAX_YEAR + 1) + (MAX_YEAR + 4) / 4
                                        - (MAX_YEAR + 100) / 100 + (MAX_YEAR + 400) / 400;

    localparam logic [SER_W-1:0] SER_LO   = SER_W'(LO_SERIAL);
    localparam logic [SER_W-1:0] SER_HI   = SER_W'(HI_SERIAL);
    localparam logic [SER_W-1:0] SER_CMAX = SER_W'(COUNT_MAX);
    localparam logic [16:0]      MAX_Y17  = 17'(MAX_YEAR);

    t_state r_state, n_state;

    // captured item
    logic [2:0]        r_func,   n_func;
    logic [DAY_W-1:0]  r_d1,     n_d1,  r_d2, n_d2;
    logic [MON_W-1:0]  r_m1,     n_m1,  r_m2, n_m2;
    logic [YEAR_W-1:0] r_y1,     n_y1,  r_y2, n_y2, r_tgt, n_tgt;
    logic [OFS_W-1:0]  r_off,    n_off;

    // year walker
    logic [Y_W-1:0]    r_yr,     n_yr;
    logic [8:0]        r_m400,   n_m400;
    logic [SER_W-1:0]  r_acc,    n_acc;
    logic [SER_W-1:0]  r_base1,  n_base1, r_base2, n_base2;
    logic              r_leap1,  n_leap1, r_leap2, n_leap2;

    // serial days and month walker
    logic [SER_W-1:0]  r_s,      n_s,   r_b, n_b;
    logic              r_neg,    n_neg;
    logic [DIY_W-1:0]  r_rem,    n_rem;
    logic [MON_W-1:0]  r_mo,     n_mo;

    // result
    logic [DAY_W-1:0]  r_rday,   n_rday;
    logic [MON_W-1:0]  r_rmon,   n_rmon;
    logic [YEAR_W-1:0] r_ryear,  n_ryear;
    logic [CNT_W-1:0]  r_cnt,    n_cnt;
    logic              r_gt,     n_gt, r_eq, n_eq, r_fvalid, n_fvalid, r_rerr, n_rerr;

    // shared adder
    logic [SER_W-1:0]  alu_a, alu_b, alu_sum;
    logic              alu_sub, alu_cout;

    // decoded conditions
    logic              leap_now;
    logic [SER_W-1:0]  ylen;
    logic [8:0]        m400_inc;
    logic              walk_end;
    logic [DIY_W-1:0]  diy1, diy2;
    logic              valid1;
    logic              out_of_range;
    logic              find_hit;
    logic [DAY_W-1:0]  mon_len;
    logic              mon_step;
    logic [CNT_W-1:0]  cnt_sat;

    cda_alu #(.W(SER_W)) u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_sub  (alu_sub),
        .o_sum  (alu_sum),
        .o_cout (alu_cout)
    );

    // year walker status
    assign leap_now = leap_of(r_m400);
    assign ylen     = leap_now ? SER_W'(366) : SER_W'(365);
    assign m400_inc = (r_m400 == CYCLE_LAST) ? 9'd0 : r_m400 + 9'd1;
    assign walk_end = (r_yr == Y_W'(r_tgt));

    // first date validity and day-of-year counts
    assign diy1   = day_in_year(r_d1, r_m1, r_leap1);
    assign diy2   = day_in_year(r_d2, r_m2, r_leap2);
    assign valid1 = (r_y1 != '0) && (17'(r_y1) <= MAX_Y17)
                    && (r_m1 >= 4'd1) && (r_m1 <= 4'd12)
                    && (r_d1 != '0) && (r_d1 <= month_len(r_m1, r_leap1));

    assign out_of_range = r_neg || (r_s < SER_LO) || (r_s > SER_HI);
    assign find_hit     = (alu_sum >= r_s);
    assign mon_len      = month_len(r_mo, leap_now);
    assign mon_step     = (r_mo < 4'd12) && (r_rem > DIY_W'(mon_len));
    assign cnt_sat      = (alu_sum > SER_CMAX) ? COUNT_MAX : alu_sum[CNT_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_WALK;
            S_WALK:   if (walk_end) n_state = S_EVAL;
            S_EVAL: begin
                case (r_func) inside
                    FN_DIFF:        n_state = S_DIFF_B;
                    FN_ADD, FN_SUB: n_state = valid1 ? S_OFS : S_DONE;
                    default:        n_state = S_DONE;
                endcase
            end
            S_DIFF_B: n_state = S_ABS1;
            S_ABS1:   n_state = alu_cout ? S_DONE : S_ABS2;
            S_ABS2:   n_state = S_DONE;
            S_OFS:    n_state = S_CHK;
            S_CHK:    n_state = out_of_range ? S_DONE : S_FIND;
            S_FIND:   if (find_hit) n_state = S_REM;
            S_REM:    n_state = S_MON;
            S_MON:    if (!mon_step) n_state = S_DONE;
            S_DONE:   if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath controls and register next values
    always_comb begin
        n_func = r_func;  n_d1 = r_d1;  n_m1 = r_m1;  n_y1 = r_y1;
        n_d2 = r_d2;  n_m2 = r_m2;  n_y2 = r_y2;  n_tgt = r_tgt;  n_off = r_off;
        n_yr = r_yr;  n_m400 = r_m400;  n_acc = r_acc;
        n_base1 = r_base1;  n_base2 = r_base2;  n_leap1 = r_leap1;  n_leap2 = r_leap2;
        n_s = r_s;  n_b = r_b;  n_neg = r_neg;  n_rem = r_rem;  n_mo = r_mo;
        n_rday = r_rday;  n_rmon = r_rmon;  n_ryear = r_ryear;  n_cnt = r_cnt;
        n_gt = r_gt;  n_eq = r_eq;  n_fvalid = r_fvalid;  n_rerr = r_rerr;
        alu_a   = r_acc;
        alu_b   = ylen;
        alu_sub = 1'b0;

        unique case (r_state)
            // capture the item, start the walk at year 0
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func = i_func;
                    n_d1 = i_first_day;   n_m1 = i_first_month;   n_y1 = i_first_year;
                    n_d2 = i_second_day;  n_m2 = i_second_month;  n_y2 = i_second_year;
                    n_off = i_offset_days;
                    n_tgt = ((i_func == FN_DIFF) && (i_second_year > i_first_year))
                            ? i_second_year : i_first_year;
                    n_yr = '0;  n_m400 = '0;  n_acc = '0;
                    n_rday = '0;  n_rmon = '0;  n_ryear = '0;  n_cnt = '0;
                    n_gt = 1'b0;  n_eq = 1'b0;  n_fvalid = 1'b0;  n_rerr = 1'b0;
                    n_neg = 1'b0;
                end
            end
            // accumulate year lengths, pick off both dates' year bases
            S_WALK: begin
                if (r_yr == Y_W'(r_y1)) begin
                    n_base1 = r_acc;
                    n_leap1 = leap_now;
                end
                if (r_yr == Y_W'(r_y2)) begin
                    n_base2 = r_acc;
                    n_leap2 = leap_now;
                end
                if (!walk_end) begin
                    n_acc  = alu_sum;
                    n_yr   = r_yr + Y_W'(1);
                    n_m400 = m400_inc;
                end
            end
            // serial of the first date, single-step operations finish here
            S_EVAL: begin
                alu_a    = r_base1;
                alu_b    = SER_W'(diy1);
                n_s      = alu_sum;
                n_fvalid = valid1;
                case (r_func)
                    FN_DOY: n_cnt = CNT_W'(diy1);
                    FN_CMP: begin
                        if (r_y1 != r_y2)      n_gt = (r_y1 > r_y2);
                        else if (r_m1 != r_m2) n_gt = (r_m1 > r_m2);
                        else if (r_d1 != r_d2) n_gt = (r_d1 > r_d2);
                        else                   n_eq = 1'b1;
                    end
                    default: ;
                endcase
            end
            // serial of the second date
            S_DIFF_B: begin
                alu_a = r_base2;
                alu_b = SER_W'(diy2);
                n_b   = alu_sum;
            end
            // absolute difference in up to two subtracts
            S_ABS1: begin
                alu_a   = r_s;
                alu_b   = r_b;
                alu_sub = 1'b1;
                if (alu_cout) n_cnt = cnt_sat;
            end
            S_ABS2: begin
                alu_a   = r_b;
                alu_b   = r_s;
                alu_sub = 1'b1;
                n_cnt   = cnt_sat;
            end
            // apply the offset; borrow marks a result before day zero
            S_OFS: begin
                alu_a   = r_s;
                alu_b   = SER_W'(r_off);
                alu_sub = (r_func == FN_SUB);
                n_s     = alu_sum;
                n_neg   = alu_sub && !alu_cout;
            end
            // range check, then restart the walker for the result year
            S_CHK: begin
                if (out_of_range) begin
                    n_rerr = 1'b1;
                end else begin
                    n_yr = '0;  n_m400 = '0;  n_acc = '0;
                end
            end
            // walk until the year that holds the serial day
            S_FIND: begin
                if (!find_hit) begin
                    n_acc  = alu_sum;
                    n_yr   = r_yr + Y_W'(1);
                    n_m400 = m400_inc;
                end
            end
            // day within the result year
            S_REM: begin
                alu_a   = r_s;
                alu_b   = r_acc;
                alu_sub = 1'b1;
                n_rem   = alu_sum[DIY_W-1:0];
                n_mo    = 4'd1;
            end
            // peel off months
            S_MON: begin
                if (mon_step) begin
                    n_rem = r_rem - DIY_W'(mon_len);
                    n_mo  = r_mo + 4'd1;
                end else begin
                    n_rday  = r_rem[DAY_W-1:0];
                    n_rmon  = r_mo;
                    n_ryear = YEAR_W'(r_yr);
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // payload and walker registers
    always_ff @(posedge i_clk) begin
        r_func <= n_func;  r_d1 <= n_d1;  r_m1 <= n_m1;  r_y1 <= n_y1;
        r_d2 <= n_d2;  r_m2 <= n_m2;  r_y2 <= n_y2;  r_tgt <= n_tgt;  r_off <= n_off;
        r_yr <= n_yr;  r_m400 <= n_m400;  r_acc <= n_acc;
        r_base1 <= n_base1;  r_base2 <= n_base2;  r_leap1 <= n_leap1;  r_leap2 <= n_leap2;
        r_s <= n_s;  r_b <= n_b;  r_neg <= n_neg;  r_rem <= n_rem;  r_mo <= n_mo;
        r_rday <= n_rday;  r_rmon <= n_rmon;  r_ryear <= n_ryear;  r_cnt <= n_cnt;
        r_gt <= n_gt;  r_eq <= n_eq;  r_fvalid <= n_fvalid;  r_rerr <= n_rerr;
    end

    // ports
    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = (r_state == S_DONE);
    assign o_result_day    = r_rday;
    assign o_result_month  = r_rmon;
    assign o_result_year   = r_ryear;
    assign o_day_count     = r_cnt;
    assign o_first_greater = r_gt;
    assign o_dates_equal   = r_eq;
    assign o_first_valid   = r_fvalid;
    assign o_range_error   = r_rerr;

endmodule

// ----- rtl/cda_checker.sv -----
// ----------------------------------------------------------------------------
// cda_checker
// Port-level checks of the date unit, bound to the top level.
// ----------------------------------------------------------------------------
module cda_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [cda_pkg::DAY_W-1:0]   o_result_day,
    input logic [cda_pkg::MON_W-1:0]   o_result_month,
    input logic [cda_pkg::YEAR_W-1:0]  o_result_year,
    input logic [cda_pkg::CNT_W-1:0]   o_day_count,
    input logic                        o_first_greater,
    input logic                        o_dates_equal,
    input logic                        o_first_valid,
    input logic                        o_range_error
);

    // one item in flight: never ready for input while a result is offered
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_day_count) && $stable(o_result_year))
        else $error("stalled result changed");

    // range error only on a valid first date, with the date fields cleared
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |->
            o_first_valid && o_result_day == '0 && o_result_month == '0
            && o_result_year == '0)
        else $error("range error with date fields set");

    // equal dates are not ordered and carry no count
    a_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dates_equal |-> !o_first_greater && o_day_count == '0)
        else $error("equal and greater both set");

    // a result date comes only from a valid, in-range first date
    a_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_month != '0 |->
            o_first_valid && !o_range_error && o_result_day != '0)
        else $error("result date from invalid input");

endmodule

bind calendar_date_arithmetic cda_checker u_cda_checker (.*);
